// ===== sv/pixc_pkg.sv =====
// Shared types, command codes, flag positions and the fixed color palette of the compositor.
package pixc_pkg;

  // Command codes carried on the input channel's tuser.
  localparam logic [1:0] CMD_RENDER = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Bit positions inside the low half of a priority word.
  localparam int FLAG_BG           = 0;
  localparam int FLAG_BG_TRANSP    = 1;
  localparam int FLAG_SPRITE       = 2;
  localparam int FLAG_SPRITE_EXTRA = 3;
  localparam int FLAG_SPRITE_ZERO  = 4;
  localparam int FLAG_BEHIND       = 5;
  localparam int FLAG_DEBUG_LOCK   = 6;

  // Lines that stay visible under the NTSC crop.
  localparam logic [8:0] CROP_TOP    = 9'd8;
  localparam logic [8:0] CROP_BOTTOM = 9'd231;

  localparam int PALETTE_SIZE = 64;

  // Red in [23:16], green in [15:8], blue in [7:0].
  localparam logic [23:0] PALETTE [PALETTE_SIZE] = '{
    24'h808080, 24'h003DA6, 24'h0012B0, 24'h440096,
    24'hA1005E, 24'hC70028, 24'hBA0600, 24'h8C1700,
    24'h5C2F00, 24'h104500, 24'h054A00, 24'h00472E,
    24'h004166, 24'h000000, 24'h050505, 24'h050505,
    24'hC7C7C7, 24'h0077FF, 24'h2155FF, 24'h8237FA,
    24'hEB2FB5, 24'hFF2950, 24'hFF2200, 24'hD63200,
    24'hC46200, 24'h358000, 24'h058F00, 24'h008A55,
    24'h0099CC, 24'h212121, 24'h090909, 24'h090909,
    24'hFFFFFF, 24'h0FD7FF, 24'h69A2FF, 24'hD480FF,
    24'hFF45F3, 24'hFF618B, 24'hFF8833, 24'hFF9C12,
    24'hFABC20, 24'h9FE30E, 24'h2BF035, 24'h0CF0A4,
    24'h05FBFF, 24'h5E5E5E, 24'h0D0D0D, 24'h0D0D0D,
    24'hFFFFFF, 24'hA6FCFF, 24'hB3ECFF, 24'hDAABEB,
    24'hFFA8F9, 24'hFFABB3, 24'hFFD2B0, 24'hFFEFA6,
    24'hFFF79C, 24'hD7E895, 24'hA6EDAF, 24'hA2F2DA,
    24'h99FFFC, 24'hDDDDDD, 24'h111111, 24'h111111
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;  // capture the input word and start the store read
    logic sweep_wr;   // write the fill value at the sweep address
    logic fill_zero;  // fill the index store with zero instead of the item index
    logic commit;     // finish the item: store writes and result load
  } pixc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] in_cmd;     // command of the word on the input channel
    logic       sweep_last; // sweep address is at the last entry
    logic       out_free;   // output register can take a result this cycle
  } pixc_stat_t;

endpackage

// ===== sv/pixel_priority_compositor.sv =====
// Top level of the pixel priority compositor: configuration register, controller and datapath.
//
//   Channel  Role          Handshake                 Contents
//   in_      command word  in_tvalid / in_tready     tuser: command; tdata: x, y, flags,
//                                                    sprite number, palette index
//   out_     result word   out_tvalid / out_tready   tuser: hit, range error; tdata: index,
//                                                    red, green, blue, priority word
//   cfg_     register bus  cfg_psel / cfg_penable    register 0 at address 0: ntsc_crop
//
// A render or read word: the accept cycle starts the read of both stores, and in the next
// cycle the old priority word comes back; once the output register is free the
// read-modify-write commits and the result is loaded. Each store has a single read port.
// A clear word sweeps both stores one entry per cycle over all FRAME_WIDTH*FRAME_HEIGHT
// entries (61440 by default), then returns its result once the output register is free.
// After reset the same sweep fills both stores with zero; no word is accepted meanwhile,
// but register writes are taken. ntsc_crop resets to 1.
// A stalled output holds its result; a new word is still accepted while it waits.
module pixel_priority_compositor #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic [63:0] in_tdata,   // [8:0] x, [17:9] y, [33:18] priority_flags,
                                  // [49:34] sprite_number, [57:50] palette_index, rest zero
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [0] sprite_zero_hit, [1] range_error
  output logic [63:0] out_tdata,  // [7:0] read_index, [15:8] read_red, [23:16] read_green,
                                  // [31:24] read_blue, [63:32] read_priority
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pixc_pkg::*;

  // The only register sits in the first word; the low address bits select bytes
  // and are not decoded.
  logic ntsc_crop_r;
  logic ntsc_crop_nxt;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];

  always_comb begin
    ntsc_crop_nxt = ntsc_crop_r;
    if (cfg_wr) begin
      ntsc_crop_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntsc_crop_r <= 1'b1;
    end else begin
      ntsc_crop_r <= ntsc_crop_nxt;
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {31'b0, ntsc_crop_r};

  // The controller sequences each word; the datapath holds the stores and the rules.
  pixc_cmd_t  ctl;
  pixc_stat_t stat;

  pixc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  pixc_dpath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .ntsc_crop  (ntsc_crop_r),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sv/pixc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module pixc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/pixc_ctrl.sv =====
// Controller state machine: reset sweep, word accept, clear sweep and commit.
module pixc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  pixc_pkg::pixc_stat_t stat,
  output pixc_pkg::pixc_cmd_t  ctl
);
  import pixc_pkg::*;

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    ctl.load_item = 1'b0;
    ctl.sweep_wr  = 1'b0;
    ctl.fill_zero = 1'b0;
    ctl.commit    = 1'b0;
    case (state_r)
      S_INIT: begin
        ctl.sweep_wr  = 1'b1;
        ctl.fill_zero = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.load_item = 1'b1;
          state_nxt = (stat.in_cmd == CMD_CLEAR) ? S_CLEAR : S_EXEC;
        end
      end
      S_CLEAR: begin
        ctl.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/pixc_dpath.sv =====
// Datapath: item registers, both pixel stores, priority rules, palette lookup, result register.
module pixc_dpath #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pixc_pkg::pixc_cmd_t  ctl,
  output pixc_pkg::pixc_stat_t stat,
  input  logic                 ntsc_crop,
  input  logic [1:0]           in_tuser,
  input  logic [63:0]          in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [1:0]           out_tuser,
  output logic [63:0]          out_tdata
);
  import pixc_pkg::*;

  localparam int          DEPTH     = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int          AW        = $clog2(DEPTH);
  localparam logic [31:0] FW_W      = 32'(FRAME_WIDTH);
  localparam logic [31:0] FH_W      = 32'(FRAME_HEIGHT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Input word fields.
  logic [8:0]  x_in;
  logic [8:0]  y_in;
  logic [31:0] lin_in;
  logic [AW-1:0] addr_in;
  logic        frame_in;

  assign x_in     = in_tdata[8:0];
  assign y_in     = in_tdata[17:9];
  assign frame_in = ({23'b0, x_in} < FW_W) && ({23'b0, y_in} < FH_W);
  assign lin_in   = {23'b0, y_in} * FW_W + {23'b0, x_in};
  assign addr_in  = lin_in[AW-1:0];

  // Captured item.
  logic [1:0]    cmd_r;
  logic [8:0]    x_r;
  logic [8:0]    y_r;
  logic [15:0]   flags_r;
  logic [15:0]   spr_r;
  logic [7:0]    index_r;
  logic [AW-1:0] addr_r;
  logic          frame_r;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_r   <= in_tuser;
      x_r     <= x_in;
      y_r     <= y_in;
      flags_r <= in_tdata[33:18];
      spr_r   <= in_tdata[49:34];
      index_r <= in_tdata[57:50];
      addr_r  <= addr_in;
      frame_r <= frame_in;
    end
  end

  // Sweep address counter, used by the reset fill and the clear command.
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] cnt_nxt;
  logic          sweep_last;

  assign sweep_last = (cnt_r == LAST_ADDR);

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.sweep_wr) begin
      cnt_nxt = sweep_last ? '0 : cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Stores.
  logic [31:0]   pri_rd;
  logic [7:0]    pix_rd;
  logic          pri_we;
  logic          pix_we;
  logic [AW-1:0] waddr;
  logic [31:0]   pri_wdata;
  logic [7:0]    pix_wdata;

  pixc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pri_ram (
    .clk   (clk),
    .we    (pri_we),
    .waddr (waddr),
    .wdata (pri_wdata),
    .re    (ctl.load_item),
    .raddr (addr_in),
    .rdata (pri_rd)
  );

  pixc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (waddr),
    .wdata (pix_wdata),
    .re    (ctl.load_item),
    .raddr (addr_in),
    .rdata (pix_rd)
  );

  // Priority rules on the old word.
  logic render_ok;
  logic read_ok;
  logic range_err;
  logic old_sprite;
  logic hit;
  logic block;
  logic cropped;

  assign render_ok  = (cmd_r == CMD_RENDER) && frame_r;
  assign read_ok    = (cmd_r == CMD_READ) && frame_r;
  assign range_err  = ((cmd_r == CMD_RENDER) || (cmd_r == CMD_READ)) && !frame_r;
  assign old_sprite = pri_rd[FLAG_SPRITE] | pri_rd[FLAG_SPRITE_EXTRA];
  assign hit        = old_sprite & flags_r[FLAG_BG] & pri_rd[FLAG_SPRITE_ZERO]
                    & ({23'b0, x_r} < (FW_W - 32'd1));
  assign cropped    = ntsc_crop & ((y_r < CROP_TOP) | (y_r > CROP_BOTTOM));
  assign block      = (old_sprite & ((flags_r[FLAG_BG] & ~pri_rd[FLAG_BEHIND])
                                   | (~flags_r[FLAG_BG] & flags_r[FLAG_BG_TRANSP])
                                   | flags_r[FLAG_SPRITE] | flags_r[FLAG_SPRITE_EXTRA]))
                    | pri_rd[FLAG_DEBUG_LOCK] | cropped;

  assign waddr     = ctl.sweep_wr ? cnt_r : addr_r;
  assign pri_we    = ctl.sweep_wr | (ctl.commit & render_ok);
  assign pix_we    = ctl.sweep_wr | (ctl.commit & render_ok & ~block);
  assign pri_wdata = ctl.sweep_wr ? 32'd0 : (pri_rd | {16'b0, flags_r} | {spr_r, 16'b0});
  assign pix_wdata = (ctl.sweep_wr && ctl.fill_zero) ? 8'd0 : index_r;

  // Result register.
  logic [23:0] rgb;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [1:0]  out_tuser_r;
  logic [63:0] out_tdata_r;

  assign rgb = (pix_rd[7:6] == 2'b00) ? PALETTE[pix_rd[5:0]] : 24'd0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_tuser_r <= {range_err, render_ok & hit};
      out_tdata_r <= read_ok ? {pri_rd, rgb[7:0], rgb[15:8], rgb[23:16], pix_rd} : 64'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  assign stat.in_cmd     = in_tuser;
  assign stat.sweep_last = sweep_last;
  assign stat.out_free   = !out_valid_r || out_tready;

endmodule
